### hw/rtl/parcel_geofence_checker_assert.svh
// Assertion macros shared by the geofence checker modules.
`ifndef PARCEL_GEOFENCE_CHECKER_ASSERT_SVH
`define PARCEL_GEOFENCE_CHECKER_ASSERT_SVH
`ifndef ASSERT_OFF
`define PGC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PGC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);
`else
`define PGC_ASSERT(lbl, prop, msg)
`define PGC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### hw/rtl/pgc_pkg.sv
`timescale 1ns / 1ps
package pgc_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int ACC_W = 68;

    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EXIT_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EXIT_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_SPAN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INVERT = 3'd5;

    localparam logic [1:0] ST_RUNNING = 2'd0;
    localparam logic [1:0] ST_SUCCESS = 2'd1;
    localparam logic [1:0] ST_FAILURE = 2'd2;

    typedef enum logic [1:0] {
        OP_SQRT,
        OP_DIV,
        OP_MAC_SET,
        OP_MAC_SUB
    } unit_op_t;

    typedef struct packed {
        logic     start;
        unit_op_t op;
    } unit_cmd_t;

    typedef struct packed {
        logic busy;
        logic acc_neg;
        logic acc_zero;
    } unit_status_t;

    typedef struct packed {
        logic signed [31:0] robot_x;
        logic signed [31:0] robot_y;
        logic               child_failed;
        logic               pose_valid;
    } in_word_t;

    typedef struct packed {
        logic [1:0] run_status;
        logic       inside_flag;
    } out_word_t;

endpackage

### hw/rtl/parcel_geofence_checker.sv
`timescale 1ns / 1ps
// Channel | Direction | Handshake          | Word
// in      | input     | in_valid/in_ready  | in_word_t robot_x, robot_y, child_failed, pose_valid
// out     | output    | out_valid/out_ready| out_word_t run_status, inside_flag
// cfg     | input     | cfg_we             | cfg_index, cfg_data
// A word on a running fence reports failure without any side check when child_failed is set
// or pose_valid is low; else each of the four fence sides is checked, and a side that straddles
// the robot runs two serial multiply passes in the shared unit.
// A word that starts a run first builds the fence: one 32-step square root and two 32-step
// divisions in the same unit; all three are skipped for a row of zero length. Reset is
// asynchronous, active low, and clears the run flag. The input is not ready while a word is
// in work; a finished result waits while the output register is full and out_ready is low.
`include "parcel_geofence_checker_assert.svh"
module parcel_geofence_checker
    import pgc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_word_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_word_t             out_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_SQ1, S_SQ2, S_SQRT, S_DIVA_GO, S_DIVA, S_DIVB_GO, S_DIVB,
        S_CORN, S_CHECK, S_EDGE, S_MAC1, S_MAC2, S_MACW, S_EVAL, S_DONE
    } state_t;

    state_t state_reg;

    logic signed [31:0] entry_x_reg, entry_y_reg, exit_x_reg, exit_y_reg;
    logic [30:0]        span_reg;
    logic               invert_reg;
    logic               inv_latched_reg;
    logic               running_reg;

    logic signed [31:0] cx_reg [4];
    logic signed [31:0] cy_reg [4];

    in_word_t           item_reg;
    logic [30:0]        hx_reg, hy_reg;
    logic               dx_sgn_pos_reg, dx_sgn_neg_reg, dy_sgn_pos_reg, dy_sgn_neg_reg;
    logic [63:0]        sq_reg;
    logic [31:0]        len_reg;
    logic [31:0]        qa_reg;
    logic [1:0]         edge_reg;
    logic               mac2_reg;
    logic               den_neg_reg;
    logic               inside_reg;
    out_word_t          res_reg;
    logic               out_valid_reg;
    out_word_t          out_data_reg;

    unit_cmd_t          cmd;
    unit_status_t       ustat;
    logic [63:0]        opa;
    logic [33:0]        opb;
    logic [31:0]        uresult;

    logic signed [32:0] dx, dy;
    logic [32:0]        mx, my;
    logic               halve;
    logic [61:0]        prod;
    logic signed [33:0] ox, oy;
    logic signed [32:0] den, a1, a2, b2;
    logic               cond;
    logic               toggle;

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sd2147483647)
        begin
            r = 32'sh7FFFFFFF;
        end
        else if (v < -34'sd2147483648)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    assign dx = 33'(exit_x_reg) - 33'(entry_x_reg);
    assign dy = 33'(exit_y_reg) - 33'(entry_y_reg);
    assign mx = dx[32] ? -dx : dx;
    assign my = dy[32] ? -dy : dy;
    assign halve = (mx[32:31] != 2'b00) || (my[32:31] != 2'b00);

    always_comb
    begin
        prod = '0;
        case (state_reg)
            S_SQ1: prod = hx_reg * hx_reg;
            S_SQ2: prod = hy_reg * hy_reg;
            S_DIVA_GO: prod = span_reg * hy_reg;
            default: prod = span_reg * hx_reg;
        endcase
    end

    always_comb
    begin
        if (hx_reg == '0 && hy_reg == '0)
        begin
            ox = '0;
            oy = 34'({1'b0, span_reg} + 32'd1) >>> 1;
        end
        else
        begin
            ox = dy_sgn_pos_reg ? -34'(qa_reg) : (dy_sgn_neg_reg ? 34'(qa_reg) : 34'sd0);
            oy = dx_sgn_pos_reg ? 34'(uresult) : (dx_sgn_neg_reg ? -34'(uresult) : 34'sd0);
        end
    end

    assign den = 33'(cy_reg[3]) - 33'(cy_reg[0]);
    assign a1 = 33'(item_reg.robot_x) - 33'(cx_reg[0]);
    assign a2 = 33'(cx_reg[3]) - 33'(cx_reg[0]);
    assign b2 = 33'(item_reg.robot_y) - 33'(cy_reg[0]);
    assign cond = (cy_reg[0] > item_reg.robot_y) != (cy_reg[3] > item_reg.robot_y);
    assign toggle = (!den_neg_reg && ustat.acc_neg)
        || (den_neg_reg && !ustat.acc_neg && !ustat.acc_zero);

    always_comb
    begin
        cmd.start = 1'b0;
        cmd.op = OP_SQRT;
        opa = '0;
        opb = '0;
        case (state_reg)
            S_SQ2:
            begin
                cmd.start = 1'b1;
                cmd.op = OP_SQRT;
                opa = sq_reg + 64'(prod);
            end
            S_DIVA_GO, S_DIVB_GO:
            begin
                cmd.start = 1'b1;
                cmd.op = OP_DIV;
                opa = 64'(prod) + 64'(len_reg);
                opb = {1'b0, len_reg, 1'b0};
            end
            S_MAC1:
            begin
                cmd.start = 1'b1;
                cmd.op = OP_MAC_SET;
                opa = 64'(a1);
                opb = 34'(den);
            end
            S_MAC2:
            begin
                cmd.start = 1'b1;
                cmd.op = OP_MAC_SUB;
                opa = 64'(a2);
                opb = 34'(b2);
            end
            default:
            begin
                cmd.start = 1'b0;
            end
        endcase
    end

    pgc_serial_unit u_unit (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .opa    (opa),
        .opb    (opb),
        .status (ustat),
        .result (uresult)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_x_reg <= '0;
            entry_y_reg <= '0;
            exit_x_reg <= '0;
            exit_y_reg <= '0;
            span_reg <= '0;
            invert_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ENTRY_X: entry_x_reg <= cfg_data;
                REG_ENTRY_Y: entry_y_reg <= cfg_data;
                REG_EXIT_X: exit_x_reg <= cfg_data;
                REG_EXIT_Y: exit_y_reg <= cfg_data;
                REG_ROW_SPAN: span_reg <= cfg_data[30:0];
                REG_INVERT: invert_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            running_reg <= 1'b0;
            inv_latched_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < 4; k++)
            begin
                cx_reg[k] <= '0;
                cy_reg[k] <= '0;
            end
        end
        else
        begin
            if (out_valid_reg && out_ready && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        item_reg <= in_data;
                        hx_reg <= halve ? mx[31:1] : mx[30:0];
                        hy_reg <= halve ? my[31:1] : my[30:0];
                        dx_sgn_pos_reg <= !dx[32] && (dx != '0);
                        dx_sgn_neg_reg <= dx[32];
                        dy_sgn_pos_reg <= !dy[32] && (dy != '0);
                        dy_sgn_neg_reg <= dy[32];
                        state_reg <= running_reg ? S_CHECK : S_SQ1;
                    end
                end
                S_SQ1:
                begin
                    sq_reg <= 64'(prod);
                    state_reg <= (hx_reg == '0 && hy_reg == '0) ? S_CORN : S_SQ2;
                end
                S_SQ2:
                begin
                    state_reg <= S_SQRT;
                end
                S_SQRT:
                begin
                    if (!ustat.busy)
                    begin
                        len_reg <= uresult;
                        state_reg <= S_DIVA_GO;
                    end
                end
                S_DIVA_GO:
                begin
                    state_reg <= S_DIVA;
                end
                S_DIVA:
                begin
                    if (!ustat.busy)
                    begin
                        qa_reg <= uresult;
                        state_reg <= S_DIVB_GO;
                    end
                end
                S_DIVB_GO:
                begin
                    state_reg <= S_DIVB;
                end
                S_DIVB:
                begin
                    if (!ustat.busy)
                    begin
                        state_reg <= S_CORN;
                    end
                end
                S_CORN:
                begin
                    cx_reg[0] <= sat32(34'(entry_x_reg) + ox);
                    cy_reg[0] <= sat32(34'(entry_y_reg) + oy);
                    cx_reg[1] <= sat32(34'(exit_x_reg) + ox);
                    cy_reg[1] <= sat32(34'(exit_y_reg) + oy);
                    cx_reg[2] <= sat32(34'(exit_x_reg) - ox);
                    cy_reg[2] <= sat32(34'(exit_y_reg) - oy);
                    cx_reg[3] <= sat32(34'(entry_x_reg) - ox);
                    cy_reg[3] <= sat32(34'(entry_y_reg) - oy);
                    inv_latched_reg <= invert_reg;
                    running_reg <= 1'b1;
                    state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    edge_reg <= '0;
                    inside_reg <= 1'b0;
                    if (item_reg.child_failed || !item_reg.pose_valid)
                    begin
                        running_reg <= 1'b0;
                        res_reg.run_status <= ST_FAILURE;
                        res_reg.inside_flag <= 1'b0;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_EDGE;
                    end
                end
                S_EDGE:
                begin
                    if (cond)
                    begin
                        den_neg_reg <= den[32];
                        state_reg <= S_MAC1;
                    end
                    else
                    begin
                        state_reg <= S_EVAL;
                    end
                end
                S_MAC1:
                begin
                    mac2_reg <= 1'b0;
                    state_reg <= S_MACW;
                end
                S_MAC2:
                begin
                    mac2_reg <= 1'b1;
                    state_reg <= S_MACW;
                end
                S_MACW:
                begin
                    if (!ustat.busy)
                    begin
                        state_reg <= mac2_reg ? S_EVAL : S_MAC2;
                    end
                end
                S_EVAL:
                begin
                    logic in_now;
                    in_now = inside_reg ^ (cond && toggle);
                    inside_reg <= in_now;
                    for (int k = 0; k < 3; k++)
                    begin
                        cx_reg[k] <= cx_reg[k+1];
                        cy_reg[k] <= cy_reg[k+1];
                    end
                    cx_reg[3] <= cx_reg[0];
                    cy_reg[3] <= cy_reg[0];
                    edge_reg <= edge_reg + 2'd1;
                    if (edge_reg == 2'd3)
                    begin
                        res_reg.inside_flag <= in_now;
                        if (in_now == inv_latched_reg)
                        begin
                            running_reg <= 1'b0;
                            res_reg.run_status <= ST_SUCCESS;
                        end
                        else
                        begin
                            res_reg.run_status <= ST_RUNNING;
                        end
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_EDGE;
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg <= res_reg;
                        state_reg <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data = out_data_reg;

    `PGC_ASSERT_NEXT(a_one_word, in_valid && in_ready, !in_ready, "accepted two words in a row")
    `PGC_ASSERT(a_idle_unit, in_ready |-> !ustat.busy, "unit busy while idle")
    `PGC_ASSERT_NEXT(a_start_wait, cmd.start, state_reg != S_IDLE, "start left no wait state")

endmodule

### hw/rtl/pgc_serial_unit.sv
`timescale 1ns / 1ps
`include "parcel_geofence_checker_assert.svh"
module pgc_serial_unit
    import pgc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  unit_cmd_t    cmd,
    input  logic [63:0]  opa,
    input  logic [33:0]  opb,
    output unit_status_t status,
    output logic [31:0]  result
);

    logic [ACC_W-1:0] w1_reg;
    logic [ACC_W-1:0] w2_reg;
    logic [63:0]      w3_reg;
    logic [33:0]      den_reg;
    logic [5:0]       cnt_reg;
    logic             busy_reg;
    unit_op_t         op_reg;

    logic [ACC_W-1:0] x;
    logic [ACC_W-1:0] y;
    logic             sub;
    logic [ACC_W-1:0] sum;
    logic             b_neg;
    logic [33:0]      b_mag;
    logic [ACC_W-1:0] a_ext;
    logic             a_neg;

    always_comb
    begin
        x = w1_reg;
        y = w2_reg;
        sub = 1'b0;
        case (op_reg)
            OP_SQRT:
            begin
                x = {w1_reg[ACC_W-3:0], w3_reg[63:62]};
                y = {w2_reg[ACC_W-3:0], 2'b01};
                sub = 1'b1;
            end
            OP_DIV:
            begin
                x = {w1_reg[ACC_W-2:0], w3_reg[63]};
                y = {{(ACC_W-34){1'b0}}, den_reg};
                sub = 1'b1;
            end
            default:
            begin
                x = w1_reg;
                y = w2_reg;
                sub = 1'b0;
            end
        endcase
        sum = x + (sub ? ~y : y) + {{(ACC_W-1){1'b0}}, sub};
    end

    assign b_neg = opb[33];
    assign b_mag = b_neg ? (~opb + 34'd1) : opb;
    assign a_neg = b_neg ^ (cmd.op == OP_MAC_SUB);
    assign a_ext = {{(ACC_W-64){opa[63]}}, opa};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
            op_reg <= OP_SQRT;
        end
        else if (cmd.start)
        begin
            busy_reg <= 1'b1;
            op_reg <= cmd.op;
            unique case (cmd.op)
                OP_SQRT:
                begin
                    cnt_reg <= 6'd32;
                    w1_reg <= '0;
                    w2_reg <= '0;
                    w3_reg <= opa;
                end
                OP_DIV:
                begin
                    cnt_reg <= 6'd32;
                    w1_reg <= {{(ACC_W-32){1'b0}}, opa[63:32]};
                    w2_reg <= '0;
                    w3_reg <= {opa[31:0], 32'd0};
                    den_reg <= opb;
                end
                OP_MAC_SET, OP_MAC_SUB:
                begin
                    cnt_reg <= 6'd33;
                    if (cmd.op == OP_MAC_SET)
                    begin
                        w1_reg <= '0;
                    end
                    w2_reg <= a_neg ? (~a_ext + {{(ACC_W-1){1'b0}}, 1'b1}) : a_ext;
                    w3_reg <= {31'd0, b_mag[32:0]};
                end
            endcase
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_reg <= 1'b0;
            end
            case (op_reg)
                OP_SQRT:
                begin
                    w3_reg <= {w3_reg[61:0], 2'b00};
                    w1_reg <= sum[ACC_W-1] ? x : sum;
                    w2_reg <= {w2_reg[ACC_W-2:0], ~sum[ACC_W-1]};
                end
                OP_DIV:
                begin
                    w3_reg <= {w3_reg[62:0], 1'b0};
                    w1_reg <= sum[ACC_W-1] ? x : sum;
                    w2_reg <= {w2_reg[ACC_W-2:0], ~sum[ACC_W-1]};
                end
                default:
                begin
                    if (w3_reg[0])
                    begin
                        w1_reg <= sum;
                    end
                    w2_reg <= {w2_reg[ACC_W-2:0], 1'b0};
                    w3_reg <= {1'b0, w3_reg[63:1]};
                end
            endcase
        end
    end

    assign status.busy = busy_reg;
    assign status.acc_neg = w1_reg[ACC_W-1];
    assign status.acc_zero = (w1_reg == '0);
    assign result = w2_reg[31:0];

    `PGC_ASSERT(a_start_idle, cmd.start |-> !busy_reg, "unit started while busy")
    `PGC_ASSERT(a_busy_count, busy_reg |-> (cnt_reg != 6'd0), "unit busy with zero count")
    `PGC_ASSERT_NEXT(a_start_busy, cmd.start, busy_reg, "unit did not go busy")

endmodule
